// ----- src/cirs_pkg.sv -----
// shared constants, types and step codes of the colored icp residual sum block
// depends on nothing; every other file imports it
`default_nettype none

package cirs_pkg;

   localparam int COORD_W  = 24;
   localparam int PACK_W   = 48;
   localparam int RGB_W    = 24;
   localparam int WEIGHT_W = 17;
   localparam int SUM_W    = 63;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd63439;
   localparam logic [SUM_W-1:0]    SUM_MAX      = {SUM_W{1'b1}};

   // sequencer steps, one register group loads per step
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_PROD  = 5'd0;
   localparam logic [STEP_W-1:0] STEP_DSUM  = 5'd1;
   localparam logic [STEP_W-1:0] STEP_DRND  = 5'd2;
   localparam logic [STEP_W-1:0] STEP_PROJ  = 5'd3;
   localparam logic [STEP_W-1:0] STEP_OFF   = 5'd4;
   localparam logic [STEP_W-1:0] STEP_GPROD = 5'd5;
   localparam logic [STEP_W-1:0] STEP_GSUM  = 5'd6;
   localparam logic [STEP_W-1:0] STEP_ERR   = 5'd7;
   localparam logic [STEP_W-1:0] STEP_ESCL  = 5'd8;
   localparam logic [STEP_W-1:0] STEP_DIV0  = 5'd9;
   localparam logic [STEP_W-1:0] STEP_DIV2  = 5'd11;
   localparam logic [STEP_W-1:0] STEP_ESQ   = 5'd12;
   localparam logic [STEP_W-1:0] STEP_WMUL  = 5'd13;
   localparam logic [STEP_W-1:0] STEP_WADD  = 5'd14;
   localparam logic [STEP_W-1:0] STEP_TERM  = 5'd15;
   localparam logic [STEP_W-1:0] STEP_ACC   = 5'd16;

   typedef struct packed {
      logic signed [COORD_W-1:0] source_x;
      logic signed [COORD_W-1:0] source_y;
      logic signed [COORD_W-1:0] source_z;
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] target_z;
      logic [PACK_W-1:0]         normal_packed;
      logic [PACK_W-1:0]         gradient_packed;
      logic [RGB_W-1:0]          source_rgb;
      logic [RGB_W-1:0]          target_rgb;
      logic                      is_last;
   } cirs_item_type;

   typedef struct packed {
      logic              capture;
      logic              busy;
      logic [STEP_W-1:0] step;
      logic              commit;
   } cirs_cmd_type;

   typedef struct packed {
      logic is_last;
      logic out_blocked;
   } cirs_status_type;

endpackage

`default_nettype wire

// ----- src/cirs_if.sv -----
// valid/ready channel interfaces for correspondence words and residual sum words
// depends on cirs_pkg for field widths
`default_nettype none

interface cirs_req_if import cirs_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] source_x;
   logic signed [COORD_W-1:0] source_y;
   logic signed [COORD_W-1:0] source_z;
   logic signed [COORD_W-1:0] target_x;
   logic signed [COORD_W-1:0] target_y;
   logic signed [COORD_W-1:0] target_z;
   logic [PACK_W-1:0]         normal_packed;
   logic [PACK_W-1:0]         gradient_packed;
   logic [RGB_W-1:0]          source_rgb;
   logic [RGB_W-1:0]          target_rgb;
   logic                      is_last;

   modport source (
      output valid, source_x, source_y, source_z, target_x, target_y, target_z,
             normal_packed, gradient_packed, source_rgb, target_rgb, is_last,
      input  ready
   );
   modport sink (
      input  valid, source_x, source_y, source_z, target_x, target_y, target_z,
             normal_packed, gradient_packed, source_rgb, target_rgb, is_last,
      output ready
   );
endinterface

interface cirs_rsp_if import cirs_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] residual_sum;
   logic             overflowed;

   modport source (output valid, residual_sum, overflowed, input ready);
   modport sink (input valid, residual_sum, overflowed, output ready);
endinterface

`default_nettype wire

// ----- src/cirs_ctrl.sv -----
// step sequencer: takes a word, walks the datapath through its steps, commits the sum
// depends on cirs_pkg
`default_nettype none

module cirs_ctrl import cirs_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output cirs_cmd_type         cmd,
   input  wire cirs_status_type status
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic              state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept;
   logic              commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // a last word waits at the final step until the output slot is free
   assign commit    = (state_ff == ST_RUN) && (step_ff == STEP_ACC)
                      && !(status.is_last && status.out_blocked);

   assign cmd.capture = accept;
   assign cmd.busy    = (state_ff == ST_RUN);
   assign cmd.step    = step_ff;
   assign cmd.commit  = commit;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               step_in  = STEP_PROD;
            end
         end
         ST_RUN: begin
            if (step_ff != STEP_ACC) begin
               step_in = step_ff + 1'b1;
            end else if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_PROD;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/cirs_datapath.sv -----
// arithmetic of one correspondence: distance, tangent offset, intensity error,
// weighted squares, saturating running sum and the output register; uses cirs_pkg
`default_nettype none

module cirs_datapath import cirs_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cirs_cmd_type        cmd,
   output cirs_status_type          status,
   input  wire cirs_item_type       item,
   input  wire logic                csr_write_enable,
   input  wire logic [WEIGHT_W-1:0] csr_write_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [SUM_W-1:0]         rsp_residual_sum,
   output logic                     rsp_overflowed
);

   localparam logic [47:0] E_SAT_LIMIT = 48'd6442450944;  // 3 * 2^31
   localparam logic [35:0] DIV_SAT     = 36'd6442450941;  // 3 * (2^31 - 1)

   function automatic logic [5:0] div3_digit(input logic [1:0] rem, input logic [3:0] nib);
      logic [5:0]  v;
      logic [10:0] p;
      logic [3:0]  q;
      logic [5:0]  r;
      v = {rem, nib};
      p = 11'(v) * 11'd43;          // v < 48, so (v * 43) >> 7 is v / 3
      q = p[10:7];
      r = v - {1'b0, q, 1'b0} - {2'b00, q};
      return {q, r[1:0]};
   endfunction

   // configuration
   logic [WEIGHT_W-1:0] weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
      end else if (csr_write_enable) begin
         weight_ff <= csr_write_data;
      end
   end

   function automatic logic en(input cirs_cmd_type c, input logic [STEP_W-1:0] s);
      return c.busy && (c.step == s);
   endfunction

   // captured word
   logic signed [24:0] dv_ff  [3];
   logic signed [15:0] nrm_ff [3];
   logic signed [15:0] grd_ff [3];
   logic signed [10:0] cdiff_ff;
   logic               last_ff;
   logic [WEIGHT_W-1:0] wg_ff, wp_ff;

   logic signed [24:0] dv_in [3];
   logic [9:0]         src_sum, tgt_sum;
   logic [WEIGHT_W-1:0] wg_in;

   always_comb begin
      dv_in[0] = {item.source_x[23], item.source_x} - {item.target_x[23], item.target_x};
      dv_in[1] = {item.source_y[23], item.source_y} - {item.target_y[23], item.target_y};
      dv_in[2] = {item.source_z[23], item.source_z} - {item.target_z[23], item.target_z};
      src_sum = 10'(item.source_rgb[7:0]) + 10'(item.source_rgb[15:8])
                + 10'(item.source_rgb[23:16]);
      tgt_sum = 10'(item.target_rgb[7:0]) + 10'(item.target_rgb[15:8])
                + 10'(item.target_rgb[23:16]);
      wg_in = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int k = 0; k < 3; k++) begin
            dv_ff[k]  <= dv_in[k];
            nrm_ff[k] <= item.normal_packed[16*k +: 16];
            grd_ff[k] <= item.gradient_packed[16*k +: 16];
         end
         cdiff_ff <= signed'({1'b0, src_sum}) - signed'({1'b0, tgt_sum});
         last_ff  <= item.is_last;
         wg_ff    <= wg_in;
         wp_ff    <= WEIGHT_ONE - wg_in;
      end
   end

   // point-to-plane distance
   logic signed [40:0] p_ff [3];
   logic signed [42:0] d30_ff;
   logic [28:0]        dmag_ff;
   logic signed [29:0] d16_ff;
   logic [42:0]        d30_mag;
   logic [42:0]        d30_rnd;

   always_comb begin
      d30_mag = d30_ff[42] ? unsigned'(-d30_ff) : unsigned'(d30_ff);
      d30_rnd = (d30_mag + 43'd8192) >> 14;
   end

   always_ff @(posedge clock) begin
      if (en(cmd, STEP_PROD)) begin
         for (int k = 0; k < 3; k++) begin
            p_ff[k] <= dv_ff[k] * nrm_ff[k];
         end
      end
      if (en(cmd, STEP_DSUM)) begin
         d30_ff <= p_ff[0] + p_ff[1] + p_ff[2];
      end
      if (en(cmd, STEP_DRND)) begin
         dmag_ff <= d30_rnd[28:0];
         d16_ff  <= d30_ff[42] ? -signed'({1'b0, d30_rnd[28:0]})
                               : signed'({1'b0, d30_rnd[28:0]});
      end
   end

   // tangent-plane offset and gradient dot product
   logic signed [45:0] q_ff [3];
   logic [57:0]        dsq_ff;
   logic signed [33:0] off_ff [3];
   logic signed [49:0] gp_ff [3];
   logic signed [51:0] go_ff;
   logic [45:0]        q_mag [3];
   logic [45:0]        q_rnd [3];
   logic signed [32:0] q_sgn [3];
   logic signed [33:0] off_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         q_mag[k]  = q_ff[k][45] ? unsigned'(-q_ff[k]) : unsigned'(q_ff[k]);
         q_rnd[k]  = (q_mag[k] + 46'd8192) >> 14;
         q_sgn[k]  = q_ff[k][45] ? -signed'({1'b0, q_rnd[k][31:0]})
                                 : signed'({1'b0, q_rnd[k][31:0]});
         off_in[k] = dv_ff[k] - q_sgn[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en(cmd, STEP_PROJ)) begin
         for (int k = 0; k < 3; k++) begin
            q_ff[k] <= d16_ff * nrm_ff[k];
         end
         dsq_ff <= dmag_ff * dmag_ff;
      end
      if (en(cmd, STEP_OFF)) begin
         for (int k = 0; k < 3; k++) begin
            off_ff[k] <= off_in[k];
         end
      end
      if (en(cmd, STEP_GPROD)) begin
         for (int k = 0; k < 3; k++) begin
            gp_ff[k] <= grd_ff[k] * off_ff[k];
         end
      end
      if (en(cmd, STEP_GSUM)) begin
         go_ff <= gp_ff[0] + gp_ff[1] + gp_ff[2];
      end
   end

   // intensity error: |e16| = round(|3e| / 768), taken as >> 8 then / 3
   logic signed [55:0] e3_ff;
   logic               esat_ff;
   logic signed [55:0] go_ext;
   logic signed [55:0] cd_ext;
   logic [55:0]        e3_mag;
   logic [47:0]        e_scaled;
   logic               e_over;

   always_comb begin
      go_ext   = 56'(go_ff);
      cd_ext   = {{21{cdiff_ff[10]}}, cdiff_ff, 24'd0};
      e3_mag   = e3_ff[55] ? unsigned'(-e3_ff) : unsigned'(e3_ff);
      e_scaled = 48'((e3_mag + 56'd384) >> 8);
      e_over   = (e_scaled >= E_SAT_LIMIT);
   end

   // divide by three, three radix-16 digits per step
   logic [35:0] dx_ff, dx_in;
   logic [35:0] dq_ff, dq_in;
   logic [1:0]  drem_ff, drem_in;
   logic [5:0]  digit;
   logic        div_step;

   assign div_step = cmd.busy && (cmd.step >= STEP_DIV0) && (cmd.step <= STEP_DIV2);

   always_comb begin
      dx_in   = dx_ff;
      dq_in   = dq_ff;
      drem_in = drem_ff;
      digit   = '0;
      for (int i = 0; i < 3; i++) begin
         digit   = div3_digit(drem_in, dx_in[35:32]);
         dq_in   = {dq_in[31:0], digit[5:2]};
         drem_in = digit[1:0];
         dx_in   = {dx_in[31:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (en(cmd, STEP_ERR)) begin
         e3_ff <= cd_ext - (go_ext + (go_ext <<< 1));
      end
      if (en(cmd, STEP_ESCL)) begin
         esat_ff <= e_over;
         dx_ff   <= e_over ? DIV_SAT : {3'd0, e_scaled[32:0]};
         dq_ff   <= '0;
         drem_ff <= '0;
      end else if (div_step) begin
         dx_ff   <= dx_in;
         dq_ff   <= dq_in;
         drem_ff <= drem_in;
      end
   end

   // weighted squares: round(w * sq / 2^16) with sq split into three slices
   logic [61:0]        esq_ff;
   logic [61:0]        sq_g, sq_p;
   logic [39:0]        gh_ff, gl_ff, ph_ff, pl_ff;
   logic [32:0]        go_lo_ff, po_lo_ff;
   logic [SUM_W-1:0]   tg_ff, tp_ff, term_ff;
   logic [63:0]        tg_in, tp_in;

   always_comb begin
      sq_g  = {4'd0, dsq_ff};
      sq_p  = esq_ff;
      tg_in = {1'b0, gh_ff, 23'd0} + 64'(gl_ff) + 64'((34'(go_lo_ff) + 34'h8000) >> 16);
      tp_in = {1'b0, ph_ff, 23'd0} + 64'(pl_ff) + 64'((34'(po_lo_ff) + 34'h8000) >> 16);
   end

   always_ff @(posedge clock) begin
      if (en(cmd, STEP_ESQ)) begin
         esq_ff <= dq_ff[30:0] * dq_ff[30:0];
      end
      if (en(cmd, STEP_WMUL)) begin
         gh_ff    <= wg_ff * sq_g[61:39];
         gl_ff    <= wg_ff * sq_g[38:16];
         go_lo_ff <= wg_ff * sq_g[15:0];
         ph_ff    <= wp_ff * sq_p[61:39];
         pl_ff    <= wp_ff * sq_p[38:16];
         po_lo_ff <= wp_ff * sq_p[15:0];
      end
      if (en(cmd, STEP_WADD)) begin
         tg_ff <= tg_in[SUM_W-1:0];
         tp_ff <= tp_in[SUM_W-1:0];
      end
      if (en(cmd, STEP_TERM)) begin
         term_ff <= tg_ff + tp_ff;
      end
   end

   // running sum and output word
   logic [SUM_W-1:0] sum_ff;
   logic             sat_ff;
   logic             rsp_valid_ff;
   logic [SUM_W-1:0] rsp_sum_ff;
   logic             rsp_ovf_ff;
   logic [SUM_W:0]   acc_wide;
   logic [SUM_W-1:0] acc_sum;
   logic             acc_sat;

   always_comb begin
      acc_wide = {1'b0, sum_ff} + {1'b0, term_ff};
      acc_sum  = acc_wide[SUM_W] ? SUM_MAX : acc_wide[SUM_W-1:0];
      acc_sat  = sat_ff || esat_ff || acc_wide[SUM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new last word may load the slot in the cycle the old word leaves
         if (cmd.commit && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.commit) begin
            if (last_ff) begin
               sum_ff <= '0;
               sat_ff <= 1'b0;
            end else begin
               sum_ff <= acc_sum;
               sat_ff <= acc_sat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && last_ff) begin
         rsp_sum_ff <= acc_sum;
         rsp_ovf_ff <= acc_sat;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_residual_sum   = rsp_sum_ff;
   assign rsp_overflowed     = rsp_ovf_ff;
   assign status.is_last     = last_ff;
   assign status.out_blocked = rsp_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

// ----- src/colored_icp_residual_sum.sv -----
// Colored ICP residual accumulator. Each correspondence word adds
// lambda*d^2 + (1-lambda)*e^2 (point-to-plane distance d, photometric error e)
// to a saturating Q31.32 running sum; the word marked last emits the sum and its
// overflow flag and clears both. The block works on one word at a time: a word
// is taken, then a step sequencer drives it through seventeen datapath steps
// (dot products, rounding, a three-step divide by three, weighting, accumulate).
// The result sits in an output register, so the next word is taken while the
// result waits; only a further last word stalls at its accumulate step until
// that register is read. The weight register takes effect on the next word
// taken; values above 1.0 act as 1.0.
// depends on cirs_pkg, cirs_if, cirs_ctrl and cirs_datapath
`default_nettype none

module colored_icp_residual_sum import cirs_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   cirs_req_if.sink                 req_chan,
   cirs_rsp_if.source               rsp_chan,
   input  wire logic                csr_write_enable,
   input  wire logic [WEIGHT_W-1:0] csr_write_data
);

   cirs_cmd_type    cmd;
   cirs_status_type status;
   cirs_item_type   item;

   always_comb begin
      item.source_x        = req_chan.source_x;
      item.source_y        = req_chan.source_y;
      item.source_z        = req_chan.source_z;
      item.target_x        = req_chan.target_x;
      item.target_y        = req_chan.target_y;
      item.target_z        = req_chan.target_z;
      item.normal_packed   = req_chan.normal_packed;
      item.gradient_packed = req_chan.gradient_packed;
      item.source_rgb      = req_chan.source_rgb;
      item.target_rgb      = req_chan.target_rgb;
      item.is_last         = req_chan.is_last;
   end

   cirs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   cirs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .item             (item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_residual_sum (rsp_chan.residual_sum),
      .rsp_overflowed   (rsp_chan.overflowed)
   );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking bench for colored_icp_residual_sum: drives correspondence words, predicts
// each residual sum word in fixed point and compares it field by field with the block
// depends on cirs_pkg and cirs_if from src and on the block itself
`default_nettype none

module tb_top import cirs_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_WORDS   = 175;
   localparam longint E_LIMIT   = 64'sd2147483647;
   localparam logic [63:0] SUM_CAP = {1'b0, SUM_MAX};
   localparam logic [COORD_W-1:0] COORD_HI = 24'h7FFFFF;
   localparam logic [COORD_W-1:0] COORD_LO = 24'h800000;
   localparam logic [PACK_W-1:0]  PACK_HI  = 48'h7FFF_7FFF_7FFF;
   localparam logic [PACK_W-1:0]  PACK_LO  = 48'h8000_8000_8000;

   typedef struct packed {
      logic [SUM_W-1:0] residual_sum;
      logic             overflowed;
   } sum_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [WEIGHT_W-1:0] csr_write_data = '0;

   cirs_req_if req_if ();
   cirs_rsp_if rsp_if ();

   colored_icp_residual_sum u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // predictor copy of the block state
   logic [WEIGHT_W-1:0] weight_copy = WEIGHT_RESET;
   logic [63:0]         sum_copy    = '0;
   bit                  sat_copy    = 1'b0;

   cirs_item_type pending_words [$];
   sum_word_type  expected_sums [$];
   cirs_item_type drv_word;

   bit calm         = 1'b0;
   bit hold_request = 1'b0;
   int failures     = 0;
   int words_sent   = 0;
   int sums_checked = 0;
   int sums_clipped = 0;
   int weight_loads = 0;

   function automatic logic [63:0] magnitude(longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
   endfunction

   // divide by 2^s, ties away from zero
   function automatic longint round_shift(longint x, int s);
      logic [63:0] q;
      q = (magnitude(x) + (64'd1 << (s - 1))) >> s;
      return (x < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [63:0] weigh_square(logic [63:0] w, logic [63:0] sq);
      return w * (sq >> 16) + ((w * sq[15:0] + 64'h8000) >> 16);
   endfunction

   function automatic void accumulate_word(input cirs_item_type w, output bit emit,
                                           output sum_word_type res);
      longint dv [3];
      longint nv [3];
      longint gv [3];
      longint d30, d16, go, e3, e16;
      logic [63:0] q, lam, dm, em, term;
      int src_i, tgt_i;
      d30 = 0;
      go  = 0;
      dv[0] = longint'($signed(w.source_x)) - longint'($signed(w.target_x));
      dv[1] = longint'($signed(w.source_y)) - longint'($signed(w.target_y));
      dv[2] = longint'($signed(w.source_z)) - longint'($signed(w.target_z));
      for (int k = 0; k < 3; k++) begin
         nv[k] = longint'($signed(w.normal_packed[16*k +: 16]));
         gv[k] = longint'($signed(w.gradient_packed[16*k +: 16]));
         d30 += dv[k] * nv[k];
      end
      d16 = round_shift(d30, 14);
      // gradient against the offset of the source within the tangent plane
      for (int k = 0; k < 3; k++)
         go += gv[k] * (dv[k] - round_shift(d16 * nv[k], 14));
      src_i = int'(w.source_rgb[7:0]) + int'(w.source_rgb[15:8]) + int'(w.source_rgb[23:16]);
      tgt_i = int'(w.target_rgb[7:0]) + int'(w.target_rgb[15:8]) + int'(w.target_rgb[23:16]);
      e3 = longint'(src_i - tgt_i) * 64'sd16777216 - 64'sd3 * go;
      q = (magnitude(e3) + 64'd384) / 64'd768;
      e16 = (e3 < 0) ? -longint'(q) : longint'(q);
      if (e16 > E_LIMIT) begin
         e16 = E_LIMIT;
         sat_copy = 1'b1;
      end else if (e16 < -E_LIMIT) begin
         e16 = -E_LIMIT;
         sat_copy = 1'b1;
      end
      lam  = (weight_copy > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(weight_copy);
      dm   = magnitude(d16);
      em   = magnitude(e16);
      term = weigh_square(lam, dm * dm) + weigh_square(64'(WEIGHT_ONE) - lam, em * em);
      if (term > SUM_CAP - sum_copy) begin
         sum_copy = SUM_CAP;
         sat_copy = 1'b1;
      end else begin
         sum_copy = sum_copy + term;
      end
      emit = w.is_last;
      res.residual_sum = sum_copy[SUM_W-1:0];
      res.overflowed   = sat_copy;
      if (emit) begin
         sum_copy = '0;
         sat_copy = 1'b0;
      end
   endfunction

   function automatic int spread(int half);
      return int'($urandom_range(0, 2 * half)) - half;
   endfunction

   function automatic cirs_item_type corr(logic [COORD_W-1:0] s, logic [COORD_W-1:0] t,
                                          logic [PACK_W-1:0] n, logic [PACK_W-1:0] g,
                                          logic [RGB_W-1:0] sc, logic [RGB_W-1:0] tc,
                                          logic last);
      cirs_item_type w;
      w.source_x = s;
      w.source_y = s;
      w.source_z = s;
      w.target_x = t;
      w.target_y = t;
      w.target_z = t;
      w.normal_packed   = n;
      w.gradient_packed = g;
      w.source_rgb = sc;
      w.target_rgb = tc;
      w.is_last    = last;
      return w;
   endfunction

   // noise words take every bit at random, the rest are nearby point pairs
   function automatic cirs_item_type random_word(bit noise, int reach, bit last);
      cirs_item_type w;
      logic [319:0] pool;
      int sx, sy, sz;
      if (noise) begin
         pool = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
         w = pool[$bits(cirs_item_type)-1:0];
      end else begin
         sx = spread(reach);
         sy = spread(reach);
         sz = spread(reach);
         w.source_x = 24'(sx);
         w.source_y = 24'(sy);
         w.source_z = 24'(sz);
         w.target_x = 24'(sx + spread(4096));
         w.target_y = 24'(sy + spread(4096));
         w.target_z = 24'(sz + spread(4096));
         w.normal_packed   = {16'(spread(16384)), 16'(spread(16384)), 16'(spread(16384))};
         w.gradient_packed = {16'(spread(4096)), 16'(spread(4096)), 16'(spread(4096))};
         w.source_rgb = 24'($urandom());
         w.target_rgb = 24'($urandom());
         w.is_last    = last;
      end
      return w;
   endfunction

   // wait for the block to drain, then let any word without a result finish
   task automatic settle_block();
      @(negedge clock);
      while (pending_words.size() != 0 || req_if.valid || expected_sums.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_weight(logic [WEIGHT_W-1:0] value);
      settle_block();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      weight_copy = value;
      weight_loads++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // correspondence word driver
   always @(posedge clock) begin
      bit emit;
      sum_word_type res;
      int gap_left;
      if (reset) begin
         gap_left = 0;
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            accumulate_word(drv_word, emit, res);
            if (emit)
               expected_sums.push_back(res);
            words_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               drv_word = pending_words.pop_front();
               req_if.source_x        <= drv_word.source_x;
               req_if.source_y        <= drv_word.source_y;
               req_if.source_z        <= drv_word.source_z;
               req_if.target_x        <= drv_word.target_x;
               req_if.target_y        <= drv_word.target_y;
               req_if.target_z        <= drv_word.target_z;
               req_if.normal_packed   <= drv_word.normal_packed;
               req_if.gradient_packed <= drv_word.gradient_packed;
               req_if.source_rgb      <= drv_word.source_rgb;
               req_if.target_rgb      <= drv_word.target_rgb;
               req_if.is_last         <= drv_word.is_last;
               req_if.valid           <= 1'b1;
               if (!calm && $urandom_range(0, 9) == 0)
                  gap_left = $urandom_range(1, 13);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // residual sum word monitor and receiver
   always @(posedge clock) begin
      sum_word_type want;
      int stall_left;
      int hold_left;
      if (reset) begin
         stall_left = 0;
         hold_left  = 0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_sums.size() == 0) begin
               $error("residual sum word with none pending: residual_sum %0d",
                      rsp_if.residual_sum);
               failures++;
            end else begin
               want = expected_sums.pop_front();
               sums_checked++;
               if (want.overflowed)
                  sums_clipped++;
               if (rsp_if.residual_sum !== want.residual_sum) begin
                  $error("residual_sum: expected %0d, got %0d",
                         want.residual_sum, rsp_if.residual_sum);
                  failures++;
               end
               if (rsp_if.overflowed !== want.overflowed) begin
                  $error("overflowed: expected %0d, got %0d",
                         want.overflowed, rsp_if.overflowed);
                  failures++;
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 11) == 0)
               stall_left = $urandom_range(1, 13);
         end
      end
   end

   // ends the run when neither side has moved a word for too long
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      logic [WEIGHT_W-1:0] phase_weight [8];
      int count, len, reach;
      bit noise;
      req_if.valid           = 1'b0;
      req_if.source_x        = '0;
      req_if.source_y        = '0;
      req_if.source_z        = '0;
      req_if.target_x        = '0;
      req_if.target_y        = '0;
      req_if.target_z        = '0;
      req_if.normal_packed   = '0;
      req_if.gradient_packed = '0;
      req_if.source_rgb      = '0;
      req_if.target_rgb      = '0;
      req_if.is_last         = 1'b0;
      rsp_if.ready           = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // corners at the reset weight
      pending_words.push_back(corr('0, '0, '0, '0, '0, '0, 1'b1));
      pending_words.push_back(corr(COORD_HI, COORD_LO, PACK_HI, PACK_HI, 24'hFFFFFF, '0, 1'b1));
      pending_words.push_back(corr(COORD_LO, COORD_HI, PACK_LO, PACK_LO, '0, 24'hFFFFFF, 1'b0));
      pending_words.push_back(corr(24'h010000, '0, 48'h0000_0000_4000, '0,
                                   24'h808080, 24'h7F7F7F, 1'b1));
      // photometric error clipped on both signs
      pending_words.push_back(corr(COORD_HI, COORD_LO, '0, PACK_HI, '0, '0, 1'b1));
      pending_words.push_back(corr(COORD_HI, COORD_LO, '0, PACK_LO, '0, '0, 1'b1));
      // two words that only add to the sum, then one that closes the set
      pending_words.push_back(corr(24'h001234, 24'hFFF000, 48'h1000_C000_2000,
                                   48'h0100_FF00_0080, 24'h102030, 24'h302010, 1'b0));
      pending_words.push_back(corr(24'hFF0000, 24'h00FFFF, 48'h4000_0000_0000,
                                   48'h7FFF_0000_8000, 24'hFFFFFF, 24'h000001, 1'b0));
      pending_words.push_back(corr(24'h000001, 24'h000000, 48'h0001_0001_0001,
                                   48'h0001_FFFF_0001, 24'h000000, 24'hFFFFFF, 1'b1));
      pending_words.push_back(corr('0, '0, '0, '0, 24'hFFFFFF, '0, 1'b1));

      // weight zero: three clipped errors drive the sum into saturation
      write_weight('0);
      pending_words.push_back(corr(COORD_HI, COORD_LO, '0, PACK_HI, '0, '0, 1'b0));
      pending_words.push_back(corr(COORD_HI, COORD_LO, '0, PACK_LO, '0, '0, 1'b0));
      pending_words.push_back(corr(COORD_HI, COORD_LO, '0, PACK_HI, '0, '0, 1'b1));
      write_weight(WEIGHT_ONE);
      pending_words.push_back(corr(COORD_HI, COORD_LO, PACK_HI, PACK_LO, 24'hFFFFFF, '0, 1'b0));
      pending_words.push_back(corr(COORD_LO, COORD_HI, PACK_LO, PACK_HI, '0, 24'hFFFFFF, 1'b1));
      // weights above one act as one
      write_weight({WEIGHT_W{1'b1}});
      pending_words.push_back(corr(COORD_HI, COORD_LO, PACK_HI, PACK_HI, 24'h00FF00, '0, 1'b0));
      pending_words.push_back(corr(24'h000100, '0, 48'h0000_4000_0000, PACK_LO,
                                   '0, 24'h0000FF, 1'b1));

      phase_weight[0] = '0;
      phase_weight[1] = WEIGHT_ONE;
      phase_weight[2] = {WEIGHT_W{1'b1}};
      phase_weight[3] = WEIGHT_ONE + 17'd1;
      phase_weight[4] = 17'($urandom_range(0, 65536));
      phase_weight[5] = WEIGHT_RESET;
      phase_weight[6] = 17'($urandom_range(65537, 131071));
      phase_weight[7] = 17'($urandom_range(0, 65536));

      for (int p = 0; p < 8; p++) begin
         write_weight(phase_weight[p]);
         if (p == 7)
            calm = 1'b1;
         count = 0;
         while (count < PHASE_WORDS) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
            noise = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
               0: reach = 256;
               1: reach = 1 << 16;
               default: reach = 1 << 22;
            endcase
            for (int i = 0; i < len; i++)
               pending_words.push_back(random_word(noise, reach, i == len - 1));
            count += len;
         end
         // close any set that a noise word left open
         pending_words.push_back(random_word(1'b0, 1 << 16, 1'b1));
         // receiver holds off long enough for a last word to back up the input
         if (p == 2)
            hold_request = 1'b1;
      end

      settle_block();
      $display("%0d correspondence words under %0d weight settings", words_sent, weight_loads);
      $display("%0d residual sums compared, %0d of them saturated", sums_checked, sums_clipped);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

// ----- colored_icp_residual_sum.f -----
src/cirs_pkg.sv
src/cirs_if.sv
src/cirs_ctrl.sv
src/cirs_datapath.sv
src/colored_icp_residual_sum.sv
bench/tb_top.sv
